@@ src/mad_pkg.sv @@
// ----------------------------------------------------------------------------
// mad_pkg: shared types and constants for the mean absolute difference block
// Sample and result widths, status codes, controller states and the command
// and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package mad_pkg;

	localparam int unsigned SAMPLE_W = 16;
	localparam int unsigned MEAN_W   = 16;
	localparam int unsigned STATUS_W = 2;

	typedef logic [STATUS_W-1:0] status_t;

	localparam status_t STATUS_OK       = 2'd0;
	localparam status_t STATUS_NO_VALID = 2'd1;
	localparam status_t STATUS_POISONED = 2'd2;
	localparam status_t STATUS_OVERFLOW = 2'd3;

	typedef enum logic [1:0] {
		ST_ACCUM,
		ST_DIVIDE,
		ST_DELIVER
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic accept;    // request taken this cycle
		logic load_div;  // closing request: snapshot and clear accumulators
		logic div_step;  // one restoring-division step
		logic load_out;  // move quotient and status into the output register
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic set_ok;    // data set being closed divides (status ok)
		logic out_free;  // output register can take a new result
	} sts_t;

endpackage

@@ src/mad_ctrl.sv @@
// ----------------------------------------------------------------------------
// mad_ctrl: sequencer for the mean absolute difference block
// Accepts requests, starts the divider on a last pair whose set divides,
// counts its steps and hands the result over to the output register.
// ----------------------------------------------------------------------------
module mad_ctrl import mad_pkg::*; #(
	parameter int unsigned SUM_W = 33
) (
	input  logic clk,
	input  logic arst_n,
	input  logic sample_valid,
	input  logic last_pair,
	input  sts_t sts,
	output cmd_t cmd,
	output logic sample_stall
);

	localparam int unsigned STEP_W = $clog2(SUM_W);

	state_t              state_q;
	state_t              state_d;
	logic   [STEP_W-1:0] step_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_ACCUM: begin
				if (sample_valid && last_pair) begin
					state_d = sts.set_ok ? ST_DIVIDE : ST_DELIVER;
				end
			end
			ST_DIVIDE: begin
				if (step_q == '0) begin
					state_d = ST_DELIVER;
				end
			end
			ST_DELIVER: begin
				if (sts.out_free) begin
					state_d = ST_ACCUM;
				end
			end
			default: state_d = ST_ACCUM;
		endcase
	end

	always_comb begin
		sample_stall = 1'b1;
		cmd          = '0;
		case (state_q)
			ST_ACCUM: begin
				sample_stall = 1'b0;
				cmd.accept   = sample_valid;
				cmd.load_div = sample_valid && last_pair;
			end
			ST_DIVIDE: begin
				cmd.div_step = 1'b1;
			end
			ST_DELIVER: begin
				cmd.load_out = sts.out_free;
			end
			default: begin
				sample_stall = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_ACCUM;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			if (cmd.load_div) begin
				step_q <= STEP_W'(SUM_W - 1);
			end else if (cmd.div_step && step_q != '0) begin
				step_q <= step_q - 1'b1;
			end
		end
	end

`ifndef SYNTHESIS
	a_divide_runs: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIVIDE && step_q != '0) |=> state_q == ST_DIVIDE)
		else $error("divider left before its last step");
`endif

endmodule

@@ src/mad_datapath.sv @@
// ----------------------------------------------------------------------------
// mad_datapath: accumulators, serial divider and output register
// Sums |eval - ref| and counts used pairs, divides sum by count one quotient
// bit per cycle and holds the result until the receiver takes it.
// ----------------------------------------------------------------------------
module mad_datapath import mad_pkg::*; #(
	parameter int unsigned MAX_PAIRS = 65536,
	parameter int unsigned CNT_W     = 17,
	parameter int unsigned SUM_W     = 33
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  cmd_t                       cmd,
	output sts_t                       sts,
	input  logic                       cfg_write,
	input  logic                       cfg_data,
	input  logic signed [SAMPLE_W-1:0] ref_value,
	input  logic signed [SAMPLE_W-1:0] eval_value,
	input  logic                       pair_valid,
	output logic                       result_valid,
	input  logic                       result_stall,
	output logic        [MEAN_W-1:0]   mean_abs_diff,
	output status_t                    status
);

	logic                     skip_invalid_q;
	logic [SUM_W-1:0]         sum_q;
	logic [CNT_W-1:0]         cnt_q;
	logic                     poisoned_q;
	logic                     ovf_q;

	logic signed [SAMPLE_W:0] diff;
	logic      [SAMPLE_W-1:0] diff_mag;
	logic                     room;
	logic                     use_pair;
	logic [SUM_W-1:0]         sum_n;
	logic [CNT_W-1:0]         cnt_n;
	logic                     poisoned_n;
	logic                     ovf_n;
	status_t                  set_status;

	logic [SUM_W-1:0]         dvd_q;
	logic [CNT_W-1:0]         dvs_q;
	logic [CNT_W-1:0]         rem_q;
	status_t                  div_status_q;
	logic [CNT_W:0]           trial;
	logic                     fits;

	logic                     out_valid_q;
	logic [MEAN_W-1:0]        out_mean_q;
	status_t                  out_status_q;

	always_comb begin
		diff       = (SAMPLE_W+1)'(eval_value) - (SAMPLE_W+1)'(ref_value);
		// magnitude of a 17-bit difference never exceeds 16 bits
		diff_mag   = SAMPLE_W'(diff[SAMPLE_W] ? -diff : diff);
		room       = (cnt_q != CNT_W'(MAX_PAIRS));
		use_pair   = pair_valid && room;
		sum_n      = use_pair ? sum_q + SUM_W'(diff_mag) : sum_q;
		cnt_n      = use_pair ? cnt_q + 1'b1 : cnt_q;
		ovf_n      = ovf_q || (pair_valid && !room);
		poisoned_n = poisoned_q || (!pair_valid && !skip_invalid_q);
		// poisoning beats overflow, overflow beats an empty set
		if (poisoned_n) begin
			set_status = STATUS_POISONED;
		end else if (ovf_n) begin
			set_status = STATUS_OVERFLOW;
		end else if (cnt_n == '0) begin
			set_status = STATUS_NO_VALID;
		end else begin
			set_status = STATUS_OK;
		end
	end

	// restoring division step
	always_comb begin
		trial = {rem_q, dvd_q[SUM_W-1]};
		fits  = (trial >= {1'b0, dvs_q});
	end

	always_comb begin
		sts.set_ok   = (set_status == STATUS_OK);
		sts.out_free = !out_valid_q || !result_stall;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skip_invalid_q <= 1'b1;
			sum_q          <= '0;
			cnt_q          <= '0;
			poisoned_q     <= 1'b0;
			ovf_q          <= 1'b0;
			out_valid_q    <= 1'b0;
		end else begin
			if (cfg_write) begin
				skip_invalid_q <= cfg_data;
			end
			if (cmd.load_div) begin
				sum_q      <= '0;
				cnt_q      <= '0;
				poisoned_q <= 1'b0;
				ovf_q      <= 1'b0;
			end else if (cmd.accept) begin
				sum_q      <= sum_n;
				cnt_q      <= cnt_n;
				poisoned_q <= poisoned_n;
				ovf_q      <= ovf_n;
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_div) begin
			// a faulted set skips the divide and reports zero
			dvd_q        <= (set_status == STATUS_OK) ? sum_n : '0;
			dvs_q        <= cnt_n;
			rem_q        <= '0;
			div_status_q <= set_status;
		end else if (cmd.div_step) begin
			rem_q <= fits ? CNT_W'(trial - {1'b0, dvs_q}) : trial[CNT_W-1:0];
			dvd_q <= {dvd_q[SUM_W-2:0], fits};
		end
		if (cmd.load_out) begin
			out_mean_q   <= dvd_q[MEAN_W-1:0];
			out_status_q <= div_status_q;
		end
	end

	assign result_valid  = out_valid_q;
	assign mean_abs_diff = out_mean_q;
	assign status        = out_status_q;

`ifndef SYNTHESIS
	a_fault_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_status_q != STATUS_OK) |-> out_mean_q == '0)
		else $error("faulted result carries a nonzero mean");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_PAIRS))
		else $error("pair count past its bound");
	a_rem_below: assert property (@(posedge clk) disable iff (!arst_n)
		$past(cmd.div_step) |-> rem_q < dvs_q)
		else $error("division remainder not below divisor");
`endif

endmodule

@@ src/mean_absolute_difference.sv @@
// ----------------------------------------------------------------------------
// mean_absolute_difference: mean of |eval - ref| over a stream of sample pairs
// Top level joining the sequencer and the datapath.
// ----------------------------------------------------------------------------
// Usage:
//   Sample channel: sample_valid / sample_stall with ref_value, eval_value,
//   pair_valid and last_pair. A request is taken on a rising edge with valid
//   high and stall low. Non-last pairs are taken back to back, one per cycle while stall is low.
//   Result channel: result_valid / result_stall with mean_abs_diff and status.
//   A last pair closes the data set: the accumulators are cleared at once and
//   a serial divider produces one quotient bit per cycle over SUM_W steps
//   (16 + clog2(MAX_PAIRS+1), 33 at default), then the result is loaded into
//   the output register. A faulted set skips the divider. sample_stall is high
//   from the last pair until the result enters the output register; a
//   waiting result does not block new pairs; after the next last pair the
//   input stays stalled until the receiver takes the held result.
//   skip_invalid is written through cfg_write / cfg_data and resets to 1.
//   Reset (arst_n low) clears sums, counts, error flags and the output valid.
// ----------------------------------------------------------------------------
module mean_absolute_difference import mad_pkg::*; #(
	parameter int unsigned MAX_PAIRS = 65536
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_write,
	input  logic                       cfg_data,
	input  logic                       sample_valid,
	output logic                       sample_stall,
	input  logic signed [SAMPLE_W-1:0] ref_value,
	input  logic signed [SAMPLE_W-1:0] eval_value,
	input  logic                       pair_valid,
	input  logic                       last_pair,
	output logic                       result_valid,
	input  logic                       result_stall,
	output logic        [MEAN_W-1:0]   mean_abs_diff,
	output status_t                    status
);

	localparam int unsigned CNT_W = $clog2(MAX_PAIRS + 1);
	localparam int unsigned SUM_W = SAMPLE_W + CNT_W;

	cmd_t cmd;
	sts_t sts;

	mad_ctrl #(
		.SUM_W (SUM_W)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.last_pair    (last_pair),
		.sts          (sts),
		.cmd          (cmd),
		.sample_stall (sample_stall)
	);

	mad_datapath #(
		.MAX_PAIRS (MAX_PAIRS),
		.CNT_W     (CNT_W),
		.SUM_W     (SUM_W)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.cfg_write     (cfg_write),
		.cfg_data      (cfg_data),
		.ref_value     (ref_value),
		.eval_value    (eval_value),
		.pair_valid    (pair_valid),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.mean_abs_diff (mean_abs_diff),
		.status        (status)
	);

endmodule
